[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the same cycle.
`define SPCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the next cycle.
`define SPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/spcd_pkg.sv]
// ----------------------------------------------------------------------------
// spcd_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package spcd_pkg;

  localparam logic [7:0]  HDR_FIRST    = 8'hEF;
  localparam logic [7:0]  HDR_SECOND   = 8'h01;
  localparam logic [15:0] ADDR_BYTES   = 16'd4;
  localparam logic [15:0] LEN_OVERHEAD = 16'd2;
  localparam logic [7:0]  LIMIT_RESET  = 8'd8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_GOT_EF  = 4'd1,
    PH_ADDR    = 4'd2,
    PH_PID     = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_CONTENT = 4'd6,
    PH_CHK_HI  = 4'd7,
    PH_CHK_LO  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_CONTENT = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_BADLEN  = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_CONTENT = 3'd1,
    OP_CHECK   = 3'd2,
    OP_BADLEN  = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_e;

  // One classified beat handed from the front end to the back end.
  // value: initial sum (INIT), content index (CONTENT) or checksum (CHECK).
  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [15:0] value;
    logic [7:0]  pid;
    logic [15:0] count;
    logic        emit;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_beat_t;

endpackage

[rtl/sum_checked_packet_deframer.sv]
// ----------------------------------------------------------------------------
// sum_checked_packet_deframer
// Deframer for EF 01 framed packets with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle (a received byte, or a timeout
// event when cmd_i is high) and delivers at most one result beat per input
// beat, so it sustains one byte per cycle as long as results are taken. A
// parser front end tracks the frame phase and hands each relevant byte as an
// operation to a four-entry queue; the back end pops one operation per cycle
// while results are taken, updates the checksum and loads the registered
// result. in_ready_o drops only when the queue is full, which happens only
// while out_ready_i is held low. content_limit is written through cfg_we_i /
// cfg_wdata_i; the user must do so only while no frame is in flight, as the
// block does not enforce it. It resets to 8.

module sum_checked_packet_deframer import spcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [7:0]  packet_id_o,
  output logic [7:0]  confirm_code_o,
  output logic        confirm_valid_o,
  output logic [15:0] content_count_o
);

  op_beat_t push;
  op_beat_t head;
  logic     q_full;
  logic     pop;

  spcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  spcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  spcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .packet_id_o     (packet_id_o),
    .confirm_code_o  (confirm_code_o),
    .confirm_valid_o (confirm_valid_o),
    .content_count_o (content_count_o)
  );

endmodule

[rtl/spcd_front.sv]
// ----------------------------------------------------------------------------
// spcd_front
// Frame parser: tracks the header, address, length and checksum phases and
// turns each byte that matters into an operation for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcd_front import spcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output op_beat_t   push_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  pid_q, pid_d;
  logic [7:0]  lenhi_q, lenhi_d;
  logic [7:0]  chkhi_q, chkhi_d;
  logic [7:0]  limit_q;

  logic        accept;
  logic [15:0] cnt_inc;
  logic [15:0] length;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 16'd1;
  assign length     = {lenhi_q, rx_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      total_q <= '0;
      pid_q   <= '0;
      lenhi_q <= '0;
      chkhi_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      pid_q   <= pid_d;
      lenhi_q <= lenhi_d;
      chkhi_q <= chkhi_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (cmd_i) begin
        phase_d = PH_HUNT;
      end else begin
        case (phase_q)
          PH_GOT_EF: begin
            phase_d = (rx_byte_i == HDR_SECOND) ? PH_ADDR : PH_HUNT;
          end
          PH_ADDR: begin
            if (cnt_inc >= ADDR_BYTES) phase_d = PH_PID;
          end
          PH_PID:    phase_d = PH_LEN_HI;
          PH_LEN_HI: phase_d = PH_LEN_LO;
          PH_LEN_LO: begin
            if (length < LEN_OVERHEAD) phase_d = PH_HUNT;
            else if (length == LEN_OVERHEAD) phase_d = PH_CHK_HI;
            else phase_d = PH_CONTENT;
          end
          PH_CONTENT: begin
            if (cnt_inc >= total_q) phase_d = PH_CHK_HI;
          end
          PH_CHK_HI: phase_d = PH_CHK_LO;
          PH_CHK_LO: phase_d = PH_HUNT;
          default: begin
            // hunting, and any unused code behaves as hunting
            phase_d = (rx_byte_i == HDR_FIRST) ? PH_GOT_EF : PH_HUNT;
          end
        endcase
      end
    end
  end

  // Held fields and the operation pushed to the queue.
  always_comb begin
    cnt_d   = cnt_q;
    total_d = total_q;
    pid_d   = pid_q;
    lenhi_d = lenhi_q;
    chkhi_d = chkhi_q;
    push_o  = '0;
    push_o.op.op  = OP_INIT;
    push_o.op.pid = pid_q;
    if (accept) begin
      if (cmd_i) begin
        push_o.valid  = 1'b1;
        push_o.op.op  = OP_TIMEOUT;
        push_o.op.pid = '0;
      end else begin
        case (phase_q)
          PH_GOT_EF: begin
            if (rx_byte_i == HDR_SECOND) cnt_d = '0;
          end
          PH_ADDR:   cnt_d   = cnt_inc;
          PH_PID:    pid_d   = rx_byte_i;
          PH_LEN_HI: lenhi_d = rx_byte_i;
          PH_LEN_LO: begin
            push_o.valid = 1'b1;
            if (length < LEN_OVERHEAD) begin
              push_o.op.op = OP_BADLEN;
            end else begin
              push_o.op.op    = OP_INIT;
              push_o.op.value = {8'd0, pid_q} + {8'd0, lenhi_q} + {8'd0, rx_byte_i};
              total_d         = length - LEN_OVERHEAD;
              cnt_d           = '0;
            end
          end
          PH_CONTENT: begin
            push_o.valid    = 1'b1;
            push_o.op.op    = OP_CONTENT;
            push_o.op.data  = rx_byte_i;
            push_o.op.value = cnt_q;
            push_o.op.emit  = cnt_q < {8'd0, limit_q};
            cnt_d           = cnt_inc;
          end
          PH_CHK_HI: chkhi_d = rx_byte_i;
          PH_CHK_LO: begin
            push_o.valid    = 1'b1;
            push_o.op.op    = OP_CHECK;
            push_o.op.value = {chkhi_q, rx_byte_i};
            push_o.op.count = total_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `SPCD_ASSERT_IMPL(a_content_nonempty, clk_i, rst_ni, phase_q == PH_CONTENT, total_q != 16'd0)
  `SPCD_ASSERT_IMPL(a_addr_bound, clk_i, rst_ni, phase_q == PH_ADDR, cnt_q < ADDR_BYTES)

endmodule

[rtl/spcd_queue.sv]
// ----------------------------------------------------------------------------
// spcd_queue
// Short register FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcd_queue import spcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  op_beat_t push_i,
  output logic     full_o,
  output op_beat_t head_o,
  input  logic     pop_i
);

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  assign full_o       = count_q == FULL_CNT;
  assign do_push      = push_i.valid && !full_o;
  assign head_o.valid = count_q != '0;
  assign head_o.op    = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

  `SPCD_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i.valid && full_o))
  `SPCD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT)

endmodule

[rtl/spcd_back.sv]
// ----------------------------------------------------------------------------
// spcd_back
// Checksum accumulator and result formatter with a registered output beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcd_back import spcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_beat_t    head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [7:0]  packet_id_o,
  output logic [7:0]  confirm_code_o,
  output logic        confirm_valid_o,
  output logic [15:0] content_count_o
);

  logic [15:0] sum_q, sum_d;
  logic [7:0]  first_q, first_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [15:0] index_q, index_d;
  logic [7:0]  pid_q, pid_d;
  logic [7:0]  conf_q, conf_d;
  logic        cvalid_q, cvalid_d;
  logic [15:0] count_q, count_d;

  logic        produces, out_free, load;
  op_t         op;

  assign op       = head_i.op;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_i.valid && (!produces || out_free);
  assign load     = pop_o && produces;

  always_comb begin
    produces = 1'b0;
    sum_d    = sum_q;
    first_d  = first_q;
    kind_d   = KIND_CONTENT;
    data_d   = '0;
    index_d  = '0;
    pid_d    = op.pid;
    conf_d   = '0;
    cvalid_d = 1'b0;
    count_d  = '0;
    case (op.op)
      OP_INIT: begin
        sum_d   = op.value;
        first_d = '0;
      end
      OP_CONTENT: begin
        produces = op.emit;
        sum_d    = sum_q + {8'd0, op.data};
        if (op.value == 16'd0) first_d = op.data;
        data_d   = op.data;
        index_d  = op.value;
      end
      OP_CHECK: begin
        produces = 1'b1;
        kind_d   = (op.value == sum_q) ? KIND_GOOD : KIND_BADSUM;
        cvalid_d = op.count != 16'd0;
        conf_d   = cvalid_d ? first_q : 8'd0;
        count_d  = op.count;
      end
      OP_BADLEN: begin
        produces = 1'b1;
        kind_d   = KIND_BADLEN;
      end
      OP_TIMEOUT: begin
        produces = 1'b1;
        kind_d   = KIND_TIMEOUT;
        pid_d    = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      first_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        sum_q   <= sum_d;
        first_q <= first_d;
      end
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      index_q  <= index_d;
      pid_q    <= pid_d;
      conf_q   <= conf_d;
      cvalid_q <= cvalid_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign byte_index_o    = index_q;
  assign packet_id_o     = pid_q;
  assign confirm_code_o  = conf_q;
  assign confirm_valid_o = cvalid_q;
  assign content_count_o = count_q;

  `SPCD_ASSERT_NEXT(a_check_reports, clk_i, rst_ni, pop_o && op.op == OP_CHECK,
    out_valid_q && (kind_q == KIND_GOOD || kind_q == KIND_BADSUM))

endmodule
